@@ hdl/ttyld_pkg.sv @@
package ttyld_pkg;

   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_NL = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_SP = 8'h20;

   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_CANONICAL_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ECHO_ENABLE    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IGNORE_CR      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_CR_TO_NL   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_NL_TO_CR   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ERASE_CHAR     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_CHARS      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_READ_LIMIT     = 4'd7;

   localparam logic [1:0] OP_ERASE    = 2'd0;
   localparam logic [1:0] OP_LINE_END = 2'd1;
   localparam logic [1:0] OP_STORE    = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       canonical_mode;
      logic       echo_enable;
      logic       ignore_cr;
      logic       map_cr_to_nl;
      logic       map_nl_to_cr;
      logic [7:0] erase_char;
      logic [7:0] min_chars;
      logic [5:0] read_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } cmd_type;

endpackage

@@ hdl/ttyld_if.sv @@
interface ttyld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ttyld_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] out_byte;
   logic [4:0] position;
   logic       last;

   modport source (output valid, output kind, output out_byte, output position,
                   output last, input ready);
   modport sink (input valid, input kind, input out_byte, input position,
                 input last, output ready);
endinterface

interface ttyld_csr_if;
   import ttyld_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [7:0]           wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ hdl/tty_line_discipline_input.sv @@
// Channel   Dir  Signals                                  Transfer
// req_chan  in   valid ready rx_byte                      one received byte
// rsp_chan  out  valid ready kind out_byte position last  one echo or line byte
// csr_chan  in   valid ready reg_index wr_data            one register write
//
// A byte enters a two-entry queue in the cycle it arrives and is dropped there if it is an
// ignored carriage return; the sequencer behind the queue takes it in its idle state, sends
// each echo byte in the echo state, and on completion starts the store read in the load state
// before sending each delivered byte in the deliver state.
// Reset is synchronous and leaves the store contents undefined; the fill count starts at zero.
// A stalled result holds only the sequencer, while the queue takes input until it is full.
module tty_line_discipline_input #(
   parameter int LINE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   ttyld_req_if.sink    req_chan,
   ttyld_rsp_if.source  rsp_chan,
   ttyld_csr_if.sink    csr_chan
);
   import ttyld_pkg::*;

   cfg_type cfg;
   cmd_type push_cmd;
   cmd_type head;
   logic    push;
   logic    full;
   logic    pop;
   logic    empty;

   ttyld_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ttyld_front u_front (
      .cfg      (cfg),
      .req_chan (req_chan),
      .q_full   (full),
      .q_push   (push),
      .q_cmd    (push_cmd)
   );

   ttyld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   ttyld_back #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_head   (head),
      .q_empty  (empty),
      .q_pop    (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ hdl/ttyld_csr.sv @@
module ttyld_csr (
   input  logic                clock,
   input  logic                reset,
   ttyld_csr_if.sink           csr_chan,
   output ttyld_pkg::cfg_type  cfg
);
   import ttyld_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            REG_CANONICAL_MODE: cfg_in.canonical_mode = csr_chan.wr_data[0];
            REG_ECHO_ENABLE:    cfg_in.echo_enable = csr_chan.wr_data[0];
            REG_IGNORE_CR:      cfg_in.ignore_cr = csr_chan.wr_data[0];
            REG_MAP_CR_TO_NL:   cfg_in.map_cr_to_nl = csr_chan.wr_data[0];
            REG_MAP_NL_TO_CR:   cfg_in.map_nl_to_cr = csr_chan.wr_data[0];
            REG_ERASE_CHAR:     cfg_in.erase_char = csr_chan.wr_data;
            REG_MIN_CHARS:      cfg_in.min_chars = csr_chan.wr_data;
            REG_READ_LIMIT:     cfg_in.read_limit = csr_chan.wr_data[5:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canonical_mode <= 1'b1;
         cfg_ff.echo_enable    <= 1'b1;
         cfg_ff.ignore_cr      <= 1'b0;
         cfg_ff.map_cr_to_nl   <= 1'b1;
         cfg_ff.map_nl_to_cr   <= 1'b0;
         cfg_ff.erase_char     <= 8'd127;
         cfg_ff.min_chars      <= 8'd1;
         cfg_ff.read_limit     <= 6'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/ttyld_front.sv @@
module ttyld_front (
   input  ttyld_pkg::cfg_type  cfg,
   ttyld_req_if.sink           req_chan,
   input  logic                q_full,
   output logic                q_push,
   output ttyld_pkg::cmd_type  q_cmd
);
   import ttyld_pkg::*;

   logic [7:0] mapped;
   logic       drop;

   assign req_chan.ready = !q_full;

   always_comb begin
      drop = cfg.ignore_cr && (req_chan.rx_byte == CH_CR);
      if (cfg.map_cr_to_nl && (req_chan.rx_byte == CH_CR)) begin
         mapped = CH_NL;
      end else if (cfg.map_nl_to_cr && (req_chan.rx_byte == CH_NL)) begin
         mapped = CH_CR;
      end else begin
         mapped = req_chan.rx_byte;
      end

      q_cmd.data = mapped;
      if (!cfg.canonical_mode) begin
         q_cmd.op = OP_STORE;
      end else if ((mapped == CH_BS) || (mapped == cfg.erase_char)) begin
         q_cmd.op = OP_ERASE;
      end else if ((mapped == CH_NL) || (mapped == CH_CR)) begin
         q_cmd.op = OP_LINE_END;
      end else begin
         q_cmd.op = OP_STORE;
      end

      q_push = req_chan.valid && !q_full && !drop;
   end

endmodule

@@ hdl/ttyld_queue.sv @@
module ttyld_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ttyld_pkg::cmd_type  push_cmd,
   output logic                full,
   input  logic                pop,
   output ttyld_pkg::cmd_type  head,
   output logic                empty
);
   import ttyld_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/ttyld_back.sv @@
module ttyld_back #(
   parameter int LINE_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  ttyld_pkg::cfg_type  cfg,
   input  ttyld_pkg::cmd_type  q_head,
   input  logic                q_empty,
   output logic                q_pop,
   ttyld_rsp_if.source         rsp_chan
);
   import ttyld_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int FW = $clog2(LINE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ECHO = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;
   localparam logic [1:0] ST_DLVR = 2'd3;

   logic [7:0]    line_mem [LINE_DEPTH];
   logic [7:0]    rdata_ff;

   logic [1:0]    state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] dlv_cnt_ff, dlv_cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [1:0]    echo_left_ff, echo_left_in;
   logic [7:0]    echo_byte_ff, echo_byte_in;
   logic          erase_ff, erase_in;
   logic          done_ff, done_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic [4:0]    rsp_pos_ff, rsp_pos_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          emit_ok;
   logic          room;
   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [FW-1:0] fill_next;
   logic [7:0]    fill8;
   logic [7:0]    lim8;
   logic [7:0]    need8;
   logic          dlv_end;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.kind     = rsp_kind_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.position = rsp_pos_ff;
   assign rsp_chan.last     = rsp_last_ff;

   assign emit_ok = !rsp_valid_ff || rsp_chan.ready;
   assign room    = (fill_ff < FW'(LINE_DEPTH));
   assign q_pop   = (state_ff == ST_IDLE) && !q_empty;
   assign dlv_end = (FW'(idx_ff) == (dlv_cnt_ff - FW'(1)));

   always_comb begin
      lim8 = {2'b00, cfg.read_limit};
      if (lim8 == 8'd0) begin
         lim8 = 8'd1;
      end else if (lim8 > 8'(LINE_DEPTH)) begin
         lim8 = 8'(LINE_DEPTH);
      end
      need8 = (cfg.min_chars == 8'd0) ? 8'd1 : cfg.min_chars;
      fill_next = room ? fill_ff + FW'(1) : fill_ff;
      fill8 = 8'(fill_next);
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dlv_cnt_in   = dlv_cnt_ff;
      idx_in       = idx_ff;
      echo_left_in = echo_left_ff;
      echo_byte_in = echo_byte_ff;
      erase_in     = erase_ff;
      done_in      = done_ff;
      mem_we       = 1'b0;
      mem_wdata    = q_head.data;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               done_in      = 1'b0;
               erase_in     = 1'b0;
               echo_left_in = 2'd0;
               echo_byte_in = q_head.data;
               case (q_head.op)
                  OP_ERASE: begin
                     if (fill_ff != '0) begin
                        fill_in      = fill_ff - FW'(1);
                        erase_in     = 1'b1;
                        echo_byte_in = CH_BS;
                        echo_left_in = cfg.echo_enable ? 2'd3 : 2'd0;
                     end
                  end
                  OP_LINE_END: begin
                     mem_we       = room;
                     mem_wdata    = CH_NL;
                     fill_in      = fill_next;
                     echo_byte_in = CH_NL;
                     echo_left_in = cfg.echo_enable ? 2'd1 : 2'd0;
                     done_in      = 1'b1;
                  end
                  OP_STORE: begin
                     mem_we       = room;
                     fill_in      = fill_next;
                     echo_left_in = cfg.echo_enable ? 2'd1 : 2'd0;
                     done_in      = cfg.canonical_mode ? (fill8 >= lim8)
                                  : ((fill8 >= need8) || (fill8 >= lim8));
                  end
                  default: begin
                     done_in = 1'b0;
                  end
               endcase
               if (done_in) begin
                  dlv_cnt_in = fill_in;
                  fill_in    = '0;
                  idx_in     = '0;
               end
               if (echo_left_in != 2'd0) begin
                  state_in = ST_ECHO;
               end else if (done_in) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_ECHO: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b0;
               rsp_byte_in  = (erase_ff && (echo_left_ff == 2'd2)) ? CH_SP : echo_byte_ff;
               rsp_pos_in   = 5'd0;
               rsp_last_in  = (echo_left_ff == 2'd1) && !done_ff;
               echo_left_in = echo_left_ff - 2'd1;
               if (echo_left_ff == 2'd1) begin
                  state_in = done_ff ? ST_LOAD : ST_IDLE;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_DLVR;
         end
         ST_DLVR: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b1;
               rsp_byte_in  = rdata_ff;
               rsp_pos_in   = 5'(idx_ff);
               rsp_last_in  = dlv_end;
               if (dlv_end) begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         echo_left_ff <= 2'd0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         echo_left_ff <= echo_left_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dlv_cnt_ff   <= dlv_cnt_in;
      echo_byte_ff <= echo_byte_in;
      erase_ff     <= erase_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[fill_ff[AW-1:0]] <= mem_wdata;
      end
      rdata_ff <= line_mem[idx_in];
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(LINE_DEPTH))
      else $error("line fill count exceeds the store depth");

   a_dlvr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DLVR) |-> (FW'(idx_ff) < dlv_cnt_ff))
      else $error("delivery index runs past the collected bytes");

   a_load_then_dlvr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (state_ff == ST_DLVR))
      else $error("store read setup not followed by delivery");

   a_echo_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ECHO) |-> (echo_left_ff != 2'd0))
      else $error("echo state entered with no echo bytes pending");

endmodule

@@ dv/tb_ttyld_scoreboard.sv @@
`timescale 1ns / 100ps

module tb_ttyld_scoreboard #(
   parameter int LINE_DEPTH = 32
) (
   input  logic clock,
   input  logic reset,
   ttyld_req_if req,
   ttyld_rsp_if rsp,
   ttyld_csr_if csr,
   output int   mismatches,
   output int   waiting,
   output int   checked
);
   import ttyld_pkg::*;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic [4:0] position;
      logic       last;
   } tty_out_type;

   localparam cfg_type CFG_AT_RESET = '{
      canonical_mode: 1'b1,
      echo_enable:    1'b1,
      ignore_cr:      1'b0,
      map_cr_to_nl:   1'b1,
      map_nl_to_cr:   1'b0,
      erase_char:     8'h7f,
      min_chars:      8'd1,
      read_limit:     6'd32
   };

   cfg_type     cfg;
   logic [7:0]  line_buf [LINE_DEPTH];
   int          fill;
   tty_out_type expected_out_q [$];

   initial begin
      mismatches = 0;
      checked = 0;
      waiting = 0;
      fill = 0;
      cfg = CFG_AT_RESET;
   end

   function automatic tty_out_type echo_item(input logic [7:0] b);
      tty_out_type item;
      item = '{kind: 1'b0, out_byte: b, position: 5'd0, last: 1'b0};
      return item;
   endfunction

   function automatic void store_byte(input logic [7:0] b);
      if (fill < LINE_DEPTH) begin
         line_buf[fill] = b;
         fill++;
      end
   endfunction

   // Works out every output transfer that one received byte causes and queues them in order.
   function automatic void predict_line_output(input logic [7:0] rx);
      logic [7:0]  c;
      int          lim;
      int          need;
      bit          done;
      tty_out_type outs [$];
      tty_out_type item;
      c = rx;
      done = 1'b0;
      lim = (cfg.read_limit == 6'd0) ? 1 : int'(cfg.read_limit);
      if (lim > LINE_DEPTH) lim = LINE_DEPTH;
      if (cfg.ignore_cr && c == CH_CR) return;
      if (cfg.map_cr_to_nl && c == CH_CR) c = CH_NL;
      else if (cfg.map_nl_to_cr && c == CH_NL) c = CH_CR;
      if (cfg.canonical_mode) begin
         if (c == CH_BS || c == cfg.erase_char) begin
            if (fill > 0) begin
               fill--;
               if (cfg.echo_enable) begin
                  outs.push_back(echo_item(CH_BS));
                  outs.push_back(echo_item(CH_SP));
                  outs.push_back(echo_item(CH_BS));
               end
            end
         end else if (c == CH_NL || c == CH_CR) begin
            store_byte(CH_NL);
            if (cfg.echo_enable) outs.push_back(echo_item(CH_NL));
            done = 1'b1;
         end else begin
            store_byte(c);
            if (cfg.echo_enable) outs.push_back(echo_item(c));
            done = (fill >= lim);
         end
      end else begin
         need = (cfg.min_chars == 8'd0) ? 1 : int'(cfg.min_chars);
         store_byte(c);
         if (cfg.echo_enable) outs.push_back(echo_item(c));
         done = (fill >= need) || (fill >= lim);
      end
      if (done) begin
         for (int i = 0; i < fill; i++) begin
            item = '{kind: 1'b1, out_byte: line_buf[i], position: 5'(i), last: 1'b0};
            outs.push_back(item);
         end
         fill = 0;
      end
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) expected_out_q.push_back(outs[i]);
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      tty_out_type got;
      tty_out_type want;
      if (reset) begin
         cfg = CFG_AT_RESET;
         fill = 0;
         expected_out_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.reg_index)
               REG_CANONICAL_MODE: cfg.canonical_mode = csr.wr_data[0];
               REG_ECHO_ENABLE:    cfg.echo_enable = csr.wr_data[0];
               REG_IGNORE_CR:      cfg.ignore_cr = csr.wr_data[0];
               REG_MAP_CR_TO_NL:   cfg.map_cr_to_nl = csr.wr_data[0];
               REG_MAP_NL_TO_CR:   cfg.map_nl_to_cr = csr.wr_data[0];
               REG_ERASE_CHAR:     cfg.erase_char = csr.wr_data;
               REG_MIN_CHARS:      cfg.min_chars = csr.wr_data;
               REG_READ_LIMIT:     cfg.read_limit = csr.wr_data[5:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) predict_line_output(req.rx_byte);
         if (rsp.valid && rsp.ready) begin
            got = '{kind: rsp.kind, out_byte: rsp.out_byte, position: rsp.position,
                    last: rsp.last};
            checked++;
            if (expected_out_q.size() == 0) begin
               $error("Unexpected output transfer: kind %0d byte 0x%02h position %0d last %0d",
                      got.kind, got.out_byte, got.position, got.last);
               mismatches++;
            end else begin
               want = expected_out_q.pop_front();
               compare_field("kind", 8'(want.kind), 8'(got.kind));
               compare_field("out_byte", want.out_byte, got.out_byte);
               compare_field("position", 8'(want.position), 8'(got.position));
               compare_field("last", 8'(want.last), 8'(got.last));
            end
         end
      end
      waiting = expected_out_q.size();
   end

endmodule

@@ dv/tb_tty_line_discipline_input.sv @@
`timescale 1ns / 100ps

module tb_tty_line_discipline_input;
   import ttyld_pkg::*;

   localparam int LINE_DEPTH = 32;
   localparam int SETTLE_CYCLES = LINE_DEPTH + 8;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int STEADY_PHASE = 5;

   logic clock = 1'b0;
   logic reset;

   ttyld_req_if req_chan ();
   ttyld_rsp_if rsp_chan ();
   ttyld_csr_if csr_chan ();

   int mismatches;
   int waiting;
   int checked;
   int bytes_sent = 0;
   int settings_used = 0;
   int hold_requests = 0;
   int holds_served = 0;
   bit steady = 1'b0;

   tty_line_discipline_input #(.LINE_DEPTH(LINE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   tb_ttyld_scoreboard #(.LINE_DEPTH(LINE_DEPTH)) scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .csr        (csr_chan),
      .mismatches (mismatches),
      .waiting    (waiting),
      .checked    (checked)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // The receiver honors a long hold-off when one is requested, then returns to random stalls.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= 21);
      end
   end

   function automatic cfg_type make_config(input bit canon, input bit echo_on, input bit ign_cr,
                                           input bit cr_nl, input bit nl_cr,
                                           input logic [7:0] erase, input logic [7:0] min_c,
                                           input logic [5:0] limit);
      cfg_type c;
      c.canonical_mode = canon;
      c.echo_enable = echo_on;
      c.ignore_cr = ign_cr;
      c.map_cr_to_nl = cr_nl;
      c.map_nl_to_cr = nl_cr;
      c.erase_char = erase;
      c.min_chars = min_c;
      c.read_limit = limit;
      return c;
   endfunction

   function automatic cfg_type random_config();
      cfg_type    c;
      int         r;
      logic [7:0] limits [8];
      logic [7:0] mins [6];
      limits = '{8'd0, 8'd1, 8'd2, 8'd31, 8'd32, 8'd33, 8'd63, 8'($urandom_range(3, 30))};
      mins = '{8'd0, 8'd1, 8'd2, 8'd255, 8'($urandom_range(3, 8)), 8'($urandom_range(9, 40))};
      c.canonical_mode = ($urandom_range(99) < 65);
      c.echo_enable = ($urandom_range(99) < 80);
      c.ignore_cr = 1'($urandom);
      c.map_cr_to_nl = 1'($urandom);
      c.map_nl_to_cr = 1'($urandom);
      r = $urandom_range(99);
      if (r < 50) c.erase_char = 8'h7f;
      else if (r < 62) c.erase_char = CH_BS;
      else if (r < 70) c.erase_char = CH_NL;
      else if (r < 78) c.erase_char = CH_CR;
      else if (r < 84) c.erase_char = 8'h00;
      else if (r < 90) c.erase_char = 8'hff;
      else c.erase_char = 8'($urandom);
      c.min_chars = mins[$urandom_range(5)];
      c.read_limit = limits[$urandom_range(7)][5:0];
      return c;
   endfunction

   // Mostly typed text with edits and line ends, plus some fully random bytes.
   function automatic logic [7:0] pick_byte(input cfg_type c);
      int r;
      r = $urandom_range(99);
      if (r < 55) return 8'($urandom_range(8'h20, 8'h7e));
      if (r < 63) return CH_BS;
      if (r < 68) return c.erase_char;
      if (r < 76) return CH_CR;
      if (r < 84) return CH_NL;
      return 8'($urandom);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 21) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_bytes(input logic [7:0] s [$]);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wr_data <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   task automatic write_config(input cfg_type c);
      write_reg(REG_CANONICAL_MODE, {7'd0, c.canonical_mode});
      write_reg(REG_ECHO_ENABLE, {7'd0, c.echo_enable});
      write_reg(REG_IGNORE_CR, {7'd0, c.ignore_cr});
      write_reg(REG_MAP_CR_TO_NL, {7'd0, c.map_cr_to_nl});
      write_reg(REG_MAP_NL_TO_CR, {7'd0, c.map_nl_to_cr});
      write_reg(REG_ERASE_CHAR, c.erase_char);
      write_reg(REG_MIN_CHARS, c.min_chars);
      write_reg(REG_READ_LIMIT, {2'd0, c.read_limit});
      csr_chan.valid <= 1'b0;
      settings_used++;
   endtask

   // Bytes that produce no output may still be in flight, so allow extra cycles.
   task automatic drain_outputs();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      cfg_type    c;
      logic [7:0] seq [$];
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      csr_chan.valid <= 1'b0;
      csr_chan.reg_index <= REG_CANONICAL_MODE;
      csr_chan.wr_data <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      seq = {8'h00, 8'hff, 8'h61, CH_BS, 8'h7f, 8'h7f, CH_BS, CH_CR, CH_NL};
      send_bytes(seq);

      drain_outputs();
      write_config(make_config(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, CH_CR, 8'd0, 6'd0));
      seq = {CH_CR, 8'h41, CH_NL, 8'h52};
      send_bytes(seq);

      drain_outputs();
      write_config(make_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CH_NL, 8'd255, 6'd63));
      seq = {8'h78, CH_NL, 8'h79, 8'h7a, CH_CR, 8'h31, 8'h32, 8'h33, 8'h34};
      send_bytes(seq);

      // The limit drops below the partial line, so the next stored byte ends the read.
      drain_outputs();
      write_config(make_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CH_NL, 8'd255, 6'd3));
      send_byte(8'h35);

      drain_outputs();
      write_config(make_config(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h7f, 8'd0, 6'd32));
      seq = {CH_CR, CH_BS};
      send_bytes(seq);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) c = make_config(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h7f, 8'd255, 6'd63);
         else c = random_config();
         drain_outputs();
         write_config(c);
         steady = (p == STEADY_PHASE);
         if (p == 0) hold_requests++;
         repeat (ITEMS_PER_PHASE) send_byte(pick_byte(c));
      end
      drain_outputs();
      steady = 1'b0;

      $display("Sent %0d received bytes under %0d register settings, with a long output stall",
               bytes_sent, settings_used);
      $display("and a stretch without idle cycles; %0d output transfers were compared.", checked);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/ttyld_pkg.sv
hdl/ttyld_if.sv
hdl/ttyld_csr.sv
hdl/ttyld_front.sv
hdl/ttyld_queue.sv
hdl/ttyld_back.sv
hdl/tty_line_discipline_input.sv
dv/tb_ttyld_scoreboard.sv
dv/tb_tty_line_discipline_input.sv
